/* sv/mtw_pkg.sv */
// Shared types and constants for the multi-task heartbeat watchdog.
package mtw_pkg;

  localparam int unsigned LIMIT_W    = 4;
  localparam int unsigned TLIMIT_W   = 3;
  localparam int unsigned WARMUP_W   = 4;
  localparam int unsigned TASK_ID_W  = 3;
  localparam int unsigned MASK_W     = 7;
  localparam int unsigned TOTAL_W    = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [LIMIT_W-1:0]  STUCK_LIMIT_RST  = 4'd6;
  localparam logic [TLIMIT_W-1:0] STUCK_TASKS_RST  = 3'd2;
  localparam logic [WARMUP_W-1:0] WARMUP_TICKS_RST = 4'd4;

  // Kind of an input transaction
  localparam logic REQ_HEARTBEAT = 1'b0;
  localparam logic REQ_TICK      = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STUCK_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STUCK_TASKS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_TICKS = 2'd2;

  typedef struct packed {
    logic [LIMIT_W-1:0]  stuck_limit;
    logic [TLIMIT_W-1:0] stuck_tasks_limit;
    logic [WARMUP_W-1:0] warmup_ticks;
  } cfg_t;

  typedef struct packed {
    logic                reset_request;
    logic [TOTAL_W-1:0]  stuck_total;
    logic [MASK_W-1:0]   stuck_mask;
  } result_t;

endpackage

/* sv/multi_task_heartbeat_watchdog_top.sv */
// Top level: stream ports, configuration registers, input and result registers.
//
//  channel | dir | handshake                     | payload
//  in_     | in  | in_tvalid / in_tready         | tuser: req_type; tdata: task_id
//  out_    | out | out_tvalid / out_tready       | tdata: stuck_mask, stuck_total, reset_req
//  cfg_    | in  | cfg_we (no wait)              | cfg_index, cfg_wdata
//
// One transaction per cycle sustained while out_tready is high; an accepted input passes
// through the input register, then the update logic into the result register.
// Reset is synchronous: control and configuration registers load their reset values, counters and marks clear.
// A stalled result holds the input register; in_tready drops only when both stages are full.
module multi_task_heartbeat_watchdog_top import mtw_pkg::*; #(
  parameter int unsigned NUM_TASKS = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [2:0] task_id, rest zero
  input  logic                  in_tuser,   // [0] req_type
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [6:0] stuck_mask, [9:7] stuck_total,
                                            // [10] reset_request, rest zero
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t                 cfg_r;
  logic                 in_valid_r;
  logic                 in_type_r;
  logic [TASK_ID_W-1:0] in_tid_r;
  logic                 out_valid_r;
  result_t              out_res_r;
  result_t              res;
  logic                 advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stuck_limit       <= STUCK_LIMIT_RST;
      cfg_r.stuck_tasks_limit <= STUCK_TASKS_RST;
      cfg_r.warmup_ticks      <= WARMUP_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STUCK_LIMIT:  cfg_r.stuck_limit       <= cfg_wdata[LIMIT_W-1:0];
        CFG_STUCK_TASKS:  cfg_r.stuck_tasks_limit <= cfg_wdata[TLIMIT_W-1:0];
        CFG_WARMUP_TICKS: cfg_r.warmup_ticks      <= cfg_wdata[WARMUP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_type_r <= in_tuser;
      in_tid_r  <= in_tdata[TASK_ID_W-1:0];
    end
  end

  mtw_core #(
    .NUM_TASKS (NUM_TASKS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .req_type (in_type_r),
    .task_id  (in_tid_r),
    .cfg      (cfg_r),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_res_r);

endmodule

/* sv/mtw_core.sv */
// Watchdog state (marks, idle counters, warm-up) and the per-transaction update.
module mtw_core import mtw_pkg::*; #(
  parameter int unsigned NUM_TASKS = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 req_type,
  input  logic [TASK_ID_W-1:0] task_id,
  input  cfg_t                 cfg,
  output result_t              res
);

  localparam int unsigned CNT_W  = $clog2(NUM_TASKS + 1);
  localparam int unsigned CMP_W  = (CNT_W > TLIMIT_W) ? CNT_W : TLIMIT_W;
  localparam int unsigned TID_XW = 5;

  logic [NUM_TASKS-1:0] marks_r, marks_nxt;
  logic [LIMIT_W-1:0]   cnt_r   [NUM_TASKS];
  logic [LIMIT_W-1:0]   cnt_nxt [NUM_TASKS];
  logic [LIMIT_W-1:0]   cnt_tick[NUM_TASKS];
  logic [WARMUP_W-1:0]  warm_r, warm_nxt, warm_dec;

  logic [LIMIT_W-1:0]   limit;
  logic [TLIMIT_W-1:0]  tlimit;
  logic [NUM_TASKS-1:0] hb_hit, stuck_hb, stuck_tick, stuck_sel;
  logic [CNT_W-1:0]     total;
  logic                 judge, fire;

  assign limit    = (cfg.stuck_limit == '0) ? LIMIT_W'(1) : cfg.stuck_limit;
  assign tlimit   = (cfg.stuck_tasks_limit == '0) ? TLIMIT_W'(1) : cfg.stuck_tasks_limit;
  assign judge    = (req_type == REQ_TICK) && (warm_r == '0);
  assign warm_dec = warm_r - WARMUP_W'(1);

  for (genvar i = 0; i < NUM_TASKS; i++) begin : g_task
    // Out-of-range ids never match any task
    assign hb_hit[i]   = (TID_XW'(task_id) == TID_XW'(i));
    assign stuck_hb[i] = (cnt_r[i] >= limit);
    assign cnt_tick[i] = marks_r[i] ? '0 :
                         (cnt_r[i] < limit) ? cnt_r[i] + LIMIT_W'(1) : cnt_r[i];
    assign stuck_tick[i] = !marks_r[i] && (cnt_tick[i] >= limit);
  end

  assign stuck_sel = judge ? stuck_tick :
                     (req_type == REQ_HEARTBEAT) ? stuck_hb : '0;

  always_comb begin
    total = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      total = total + CNT_W'(stuck_sel[i]);
    end
  end

  assign fire = judge && (CMP_W'(total) >= CMP_W'(tlimit));

  always_comb begin
    res.stuck_mask = '0;
    for (int j = 0; j < MASK_W; j++) begin
      if (j < NUM_TASKS) begin
        res.stuck_mask[j] = stuck_sel[j];
      end
    end
    res.stuck_total   = (CMP_W'(total) > CMP_W'(7)) ? TOTAL_W'(7) : TOTAL_W'(total);
    res.reset_request = fire;
  end

  always_comb begin
    marks_nxt = marks_r;
    warm_nxt  = warm_r;
    for (int i = 0; i < NUM_TASKS; i++) begin
      cnt_nxt[i] = cnt_r[i];
    end
    if (req_type == REQ_HEARTBEAT) begin
      marks_nxt = marks_r | hb_hit;
    end else if (!judge) begin
      warm_nxt = warm_dec;
      if (warm_dec == '0) begin
        marks_nxt = '0;
      end
    end else if (fire) begin
      marks_nxt = '0;
      warm_nxt  = cfg.warmup_ticks;
      for (int i = 0; i < NUM_TASKS; i++) begin
        cnt_nxt[i] = '0;
      end
    end else begin
      marks_nxt = '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        cnt_nxt[i] = cnt_tick[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marks_r <= '0;
      warm_r  <= WARMUP_TICKS_RST;
      for (int i = 0; i < NUM_TASKS; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (step) begin
      marks_r <= marks_nxt;
      warm_r  <= warm_nxt;
      for (int i = 0; i < NUM_TASKS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

`ifndef SYNTH
  a_fire_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.reset_request |=> (marks_r == '0) && (warm_r == $past(cfg.warmup_ticks)))
    else $error("state not cleared after reset request");

  a_hb_keeps_warmup: assert property (@(posedge clk) disable iff (!rst_n)
    step && (req_type == REQ_HEARTBEAT) |=> $stable(warm_r))
    else $error("heartbeat changed warm-up count");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(marks_r) && $stable(warm_r))
    else $error("state moved without a transaction");

  a_fire_has_stuck: assert property (@(posedge clk) disable iff (!rst_n)
    res.reset_request |-> (res.stuck_total != '0) && (warm_r == '0))
    else $error("reset request without stuck tasks");
`endif

endmodule
